>>> rtl/core/ltt_pkg.sv
// Shared types, constants and codes of the lockless transposition table.
`timescale 1ns / 1ps

package ltt_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 65536;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   // Field widths
   localparam int KEY_W     = 64;
   localparam int MOVE_W    = 16;
   localparam int SCORE_W   = 16;
   localparam int DEPTH_W   = 8;
   localparam int BOUND_W   = 2;
   localparam int PAYLOAD_W = MOVE_W + SCORE_W + DEPTH_W + BOUND_W;
   localparam int WORD_W    = KEY_W + PAYLOAD_W;

   // Stream widths
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   // Operation codes
   typedef enum logic [1:0] {
      OP_PROBE  = 2'd0,
      OP_STORE  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_EXACT_BOUND = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NULL_MOVE   = 1'b1;

   // Register reset values
   localparam logic [BOUND_W-1:0] EXACT_BOUND_RESET = 2'd3;
   localparam logic [MOVE_W-1:0]  NULL_MOVE_RESET   = '0;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   // Slot payload: move in the lowest bits, bound in the highest
   typedef struct packed {
      logic [BOUND_W-1:0]        bound;
      logic signed [DEPTH_W-1:0] depth;
      logic signed [SCORE_W-1:0] score;
      logic [MOVE_W-1:0]         move;
   } payload_type;

   // One memory word: check key over payload
   typedef struct packed {
      logic [KEY_W-1:0] check;
      payload_type      payload;
   } slot_word_type;

   // One request held during its lookup
   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
      payload_type      payload;
   } request_type;

   // Outcome of checking one slot against a request
   typedef struct packed {
      logic          hit;
      logic          write;
      payload_type   found;
      slot_word_type new_word;
   } lookup_type;

endpackage

>>> rtl/core/ltt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ltt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ltt_slot_check.sv
// Key check and depth-preferred replacement of one table slot.
`timescale 1ns / 1ps

module ltt_slot_check
   import ltt_pkg::*;
(
   input  slot_word_type      slot,
   input  request_type        req,
   input  logic [BOUND_W-1:0] exact_bound,
   input  logic [MOVE_W-1:0]  null_move,
   output lookup_type         result
);

   logic        same;
   logic        drop;
   payload_type merged;

   always_comb begin
      // Recover the stored key from the check word
      same = ((slot.check ^ {{(KEY_W-PAYLOAD_W){1'b0}}, slot.payload}) == req.key);

      // Drop a shallower store of the same key unless its bound is exact
      drop = same && (slot.payload.depth > req.payload.depth)
             && (req.payload.bound != exact_bound);

      // Keep the old move when the new one is the null move
      merged = req.payload;
      if (same && (req.payload.move == null_move)) begin
         merged.move = slot.payload.move;
      end

      result.hit              = same;
      result.write            = (req.op == OP_STORE) && !drop;
      result.found            = same ? slot.payload : '0;
      result.new_word.payload = merged;
      result.new_word.check   = req.key ^ {{(KEY_W-PAYLOAD_W){1'b0}}, merged};
   end

endmodule

>>> rtl/core/lockless_transposition_table.sv
// Top level of the lockless transposition table: sequencer, registers and table memory.
`timescale 1ns / 1ps

// Direct-mapped transposition table of TABLE_ENTRIES slots, indexed by the low key bits.
// Each slot keeps a 42-bit payload and the key XOR payload in one memory word. A probe
// (op 0) returns one result; store (op 1), clear (op 2) and op 3 return none. The slot is
// read in the accept cycle and checked in the next, where a store is written back and a
// probe is answered once the output register is free; req_tready is low during the check
// and while a probe result waits in a full output register. After reset, and after each
// clear, a clearing pass writes zero to one slot a cycle over all TABLE_ENTRIES slots, with
// req_tready low; configuration writes are taken throughout. An all-zero slot matches key 0.

module lockless_transposition_table
   import ltt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // key, score, depth, bound, move, zero fill
   input  logic [1:0]            req_tuser,  // op
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found_move, found_score, found_depth,
                                             // found_bound, zero fill
   output logic                  rsp_tuser,  // hit
   // Configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   request_type        req_ff, req_in;
   logic [BOUND_W-1:0] exact_bound_ff, exact_bound_in;
   logic [MOVE_W-1:0]  null_move_ff, null_move_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               hit_ff, hit_in;
   payload_type        found_ff, found_in;

   request_type        req_new;
   logic               accept;
   logic               rsp_free;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   slot_word_type      ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]  ram_rd_data;
   slot_word_type      slot;
   lookup_type         look;

   // Unpack the request transfer
   assign req_new.op            = op_type'(req_tuser);
   assign req_new.key           = req_tdata[63:0];
   assign req_new.payload.score = req_tdata[79:64];
   assign req_new.payload.depth = req_tdata[87:80];
   assign req_new.payload.bound = req_tdata[89:88];
   assign req_new.payload.move  = req_tdata[105:90];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Table memory
   assign ram_rd_en   = accept;
   assign ram_rd_addr = req_new.key[IDX_W-1:0];
   assign slot        = slot_word_type'(ram_rd_data);

   ltt_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ltt_slot_check u_check (
      .slot        (slot),
      .req         (req_ff),
      .exact_bound (exact_bound_ff),
      .null_move   (null_move_ff),
      .result      (look)
   );

   // Configuration registers
   always_comb begin
      exact_bound_in = exact_bound_ff;
      null_move_in   = null_move_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_EXACT_BOUND: exact_bound_in = csr_wdata[BOUND_W-1:0];
            CSR_NULL_MOVE:   null_move_in   = csr_wdata[MOVE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: clearing pass, accept, then check and write back or answer
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hit_in       = hit_ff;
      found_in     = found_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = req_ff.key[IDX_W-1:0];
      ram_wr_data  = look.new_word;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
            ram_wr_data = '0;
            clr_idx_in  = clr_idx_ff + 1'b1;
            if (clr_idx_ff == {IDX_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_new;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            case (req_ff.op)
               OP_PROBE: begin
                  // Hold until the output register is free
                  if (rsp_free) begin
                     rsp_valid_in = 1'b1;
                     hit_in       = look.hit;
                     found_in     = look.found;
                     state_in     = ST_IDLE;
                  end
               end
               OP_STORE: begin
                  ram_wr_en = look.write;
                  state_in  = ST_IDLE;
               end
               OP_CLEAR: begin
                  clr_idx_in = '0;
                  state_in   = ST_CLEAR;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         exact_bound_ff <= EXACT_BOUND_RESET;
         null_move_ff   <= NULL_MOVE_RESET;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         exact_bound_ff <= exact_bound_in;
         null_move_ff   <= null_move_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
   end

   // Result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PAYLOAD_W){1'b0}}, found_ff};

   // An accepted request is checked in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted request did not enter lookup");

   // The memory is never read and written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("table read and write overlap");

   // A new result comes only from a probe lookup
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |->
         $past(state_ff == ST_LOOKUP && req_ff.op == OP_PROBE))
      else $error("result raised without a probe");

   // A probe waiting on a full output register stays in lookup
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && req_ff.op == OP_PROBE && !rsp_free)
         |=> (state_ff == ST_LOOKUP))
      else $error("probe left lookup while result still pending");

   // Outside a clearing pass the table is written only by a store
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff != ST_CLEAR) |-> (req_ff.op == OP_STORE))
      else $error("table write without a store");

endmodule

>>> verif/tb_lockless_transposition_table.sv
// Self-checking testbench of the lockless transposition table: probe, store, clear, registers.
`timescale 1ns / 1ps

module tb_lockless_transposition_table;
   import ltt_pkg::*;

   // Longest receiver hold-off and the idle limit of the watchdog; the limit covers the
   // clearing pass over all TABLE_ENTRIES slots plus the longest stall, several times over
   localparam int LONG_HOLD  = 400;
   localparam int IDLE_LIMIT = 300000;
   localparam int HOT_SLOTS  = 8;
   localparam int HOT_PER    = 3;

   // Expected answer of one probe
   typedef struct packed {
      logic                      hit;
      logic [MOVE_W-1:0]         move;
      logic signed [SCORE_W-1:0] score;
      logic signed [DEPTH_W-1:0] depth;
      logic [BOUND_W-1:0]        bound;
   } probe_answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Table image and register copies of the predictor
   logic [KEY_W-1:0]  slot_check [int];
   payload_type       slot_pay [int];
   logic [BOUND_W-1:0] exact_code = EXACT_BOUND_RESET;
   logic [MOVE_W-1:0]  null_move  = NULL_MOVE_RESET;

   probe_answer_type answers_due [$];
   logic [KEY_W-1:0] hot_keys [HOT_SLOTS*HOT_PER];

   int  mismatches = 0;
   int  probes_sent = 0, stores_sent = 0, stores_dropped = 0, clears_sent = 0;
   int  hits_seen = 0, answers_seen = 0, reg_writes = 0;
   bit  steady_mode = 1'b0;
   bit  rsp_steady = 1'b0;
   int  hold_asked = 0;

   lockless_transposition_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 16);
      return $urandom_range(40, 150);
   endfunction

   // Apply one accepted request to the table image; queue the answer of a probe
   task automatic predict_table_access(input op_type op, input logic [KEY_W-1:0] key,
                                       input payload_type req_pay);
      int               slot;
      payload_type      old_pay;
      logic [KEY_W-1:0] old_check;
      logic             same;
      payload_type      new_pay;
      probe_answer_type ans;
      slot      = int'(key[IDX_W-1:0]);
      old_pay   = slot_pay.exists(slot) ? slot_pay[slot] : '0;
      old_check = slot_check.exists(slot) ? slot_check[slot] : '0;
      same      = ((old_check ^ {{(KEY_W-PAYLOAD_W){1'b0}}, old_pay}) == key);
      case (op)
         OP_PROBE: begin
            probes_sent++;
            ans = '0;
            if (same) begin
               ans.hit   = 1'b1;
               ans.move  = old_pay.move;
               ans.score = old_pay.score;
               ans.depth = old_pay.depth;
               ans.bound = old_pay.bound;
            end
            answers_due.push_back(ans);
         end
         OP_STORE: begin
            stores_sent++;
            new_pay = req_pay;
            // Deeper entry of the same position survives unless the bound is exact
            if (same && ($signed(old_pay.depth) > $signed(req_pay.depth)) &&
                (req_pay.bound != exact_code)) begin
               stores_dropped++;
            end else begin
               if (same && (req_pay.move == null_move))
                  new_pay.move = old_pay.move;
               slot_pay[slot]   = new_pay;
               slot_check[slot] = key ^ {{(KEY_W-PAYLOAD_W){1'b0}}, new_pay};
            end
         end
         OP_CLEAR: begin
            clears_sent++;
            slot_pay.delete();
            slot_check.delete();
         end
         default: ;
      endcase
   endtask

   // Offer one request after a random gap and hold it until the transfer
   task automatic send_request(input op_type op, input logic [KEY_W-1:0] key,
                               input logic signed [SCORE_W-1:0] score,
                               input logic signed [DEPTH_W-1:0] depth,
                               input logic [BOUND_W-1:0] bound,
                               input logic [MOVE_W-1:0] move);
      int          gap;
      payload_type pay;
      gap = steady_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pay.move  = move;
      pay.score = score;
      pay.depth = depth;
      pay.bound = bound;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      // Key lowest, then score, depth, bound and move
      req_tdata  <= {{(REQ_DATA_W-KEY_W-PAYLOAD_W){1'b0}}, move, bound, depth, score, key};
      do @(posedge clock); while (!req_tready);
      predict_table_access(op, key, pay);
   endtask

   // Lower the request valid and wait until every answer is back, then let a store settle
   task automatic wait_answers_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; only called with the block drained
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      if (addr == CSR_EXACT_BOUND) exact_code = value[BOUND_W-1:0];
      else                         null_move  = value[MOVE_W-1:0];
      reg_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Build a pool of keys that share a few slots, so stores and probes collide
   task automatic refill_hot_keys();
      logic [IDX_W-1:0] slot;
      for (int s = 0; s < HOT_SLOTS; s++) begin
         slot = (s == 0) ? '0 : (s == 1) ? '1 : IDX_W'($urandom);
         for (int k = 0; k < HOT_PER; k++) begin
            hot_keys[s*HOT_PER+k] = {$urandom, $urandom};
            hot_keys[s*HOT_PER+k][IDX_W-1:0] = slot;
         end
      end
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(0, 99);
      if (r < 80) return hot_keys[$urandom_range(0, HOT_SLOTS*HOT_PER-1)];
      if (r < 92) return {$urandom, $urandom};
      if (r < 96) return '0;
      // Empty-looking slot reached by a key whose only set bits are high
      k = {$urandom, $urandom};
      k[IDX_W-1:0] = '0;
      return k;
   endfunction

   // Mostly probes and stores on colliding keys, a few unused op codes
   task automatic send_random_request();
      int r;
      op_type op;
      logic signed [DEPTH_W-1:0] depth;
      logic [MOVE_W-1:0] move;
      r = $urandom_range(0, 99);
      op = (r < 45) ? OP_PROBE : (r < 95) ? OP_STORE : OP_UNUSED;
      depth = $urandom_range(0, 1) ? DEPTH_W'($urandom)
                                   : DEPTH_W'($urandom_range(0, 8)) - DEPTH_W'(4);
      move = ($urandom_range(0, 99) < 30) ? null_move : MOVE_W'($urandom);
      send_request(op, pick_key(), SCORE_W'($urandom), depth, BOUND_W'($urandom), move);
   endtask

   task automatic run_random_phase(input int count);
      refill_hot_keys();
      send_request(OP_CLEAR, {$urandom, $urandom}, '0, '0, '0, '0);
      for (int i = 0; i < count; i++) begin
         // Alternate stretches with and without idling
         if (i % 64 == 0) begin
            steady_mode = ($urandom_range(0, 3) == 0);
            rsp_steady  = ($urandom_range(0, 3) == 0);
         end
         send_random_request();
      end
      steady_mode = 1'b0;
      rsp_steady  = 1'b0;
      wait_answers_drained();
   endtask

   // Field extremes, replacement rule, null move, key collision, unused op, clear
   task automatic test_directed_cases();
      logic [KEY_W-1:0] k_ones, k_twin;
      k_ones = '1;
      k_twin = {1'b1, {(KEY_W-1-IDX_W){1'b0}}, {IDX_W{1'b1}}};
      // An empty slot answers key 0 with zero fields, any other key misses
      send_request(OP_PROBE, '0, '0, '0, '0, '0);
      send_request(OP_PROBE, k_ones, '1, '1, '1, '1);
      send_request(OP_STORE, k_ones, 16'sh7FFF, 8'sh7F, 2'd0, 16'hFFFF);
      send_request(OP_PROBE, k_ones, '0, '0, '0, '0);
      // Shallower, inexact store of the same key is dropped
      send_request(OP_STORE, k_ones, 16'sh0001, 8'sh80, 2'd1, 16'h0001);
      send_request(OP_PROBE, k_ones, '0, '0, '0, '0);
      // Exact bound always replaces; null move keeps the stored move
      send_request(OP_STORE, k_ones, 16'sh8000, 8'sh80, 2'd3, NULL_MOVE_RESET);
      send_request(OP_PROBE, k_ones, '0, '0, '0, '0);
      // Equal or greater depth replaces
      send_request(OP_STORE, k_ones, 16'sh1234, 8'sh80, 2'd2, 16'h1234);
      send_request(OP_STORE, k_ones, 16'sh8000, 8'sh7F, 2'd0, 16'hABCD);
      send_request(OP_PROBE, k_ones, '0, '0, '0, '0);
      // Different key in the same slot misses, then always overwrites
      send_request(OP_PROBE, k_twin, '0, '0, '0, '0);
      send_request(OP_STORE, k_twin, 16'sh0042, 8'sh81, 2'd1, NULL_MOVE_RESET);
      send_request(OP_PROBE, k_twin, '0, '0, '0, '0);
      send_request(OP_PROBE, k_ones, '0, '0, '0, '0);
      // Unused op code leaves the table alone
      send_request(OP_UNUSED, k_twin, '1, '1, '1, '1);
      send_request(OP_PROBE, k_twin, '0, '0, '0, '0);
      // Clear wipes the slot
      send_request(OP_CLEAR, '1, '1, '1, '1, '1);
      send_request(OP_PROBE, k_twin, '0, '0, '0, '0);
      send_request(OP_PROBE, '0, '0, '0, '0, '0);
      wait_answers_drained();
   endtask

   // Walk through register settings, the extremes among them
   task automatic test_register_settings();
      write_reg(CSR_EXACT_BOUND, CSR_DATA_W'(0));
      write_reg(CSR_NULL_MOVE, 16'hFFFF);
      run_random_phase(280);
      write_reg(CSR_EXACT_BOUND, CSR_DATA_W'(1));
      write_reg(CSR_NULL_MOVE, CSR_DATA_W'($urandom));
      run_random_phase(280);
      write_reg(CSR_EXACT_BOUND, CSR_DATA_W'(2));
      write_reg(CSR_NULL_MOVE, 16'h0000);
      run_random_phase(280);
   endtask

   // Hold off the receiver while probes keep coming, so the input stalls
   task automatic test_backpressure();
      steady_mode = 1'b1;
      hold_asked++;
      for (int i = 0; i < 40; i++)
         send_request(OP_PROBE, pick_key(), SCORE_W'($urandom), DEPTH_W'($urandom),
                      BOUND_W'($urandom), MOVE_W'($urandom));
      steady_mode = 1'b0;
      wait_answers_drained();
   endtask

   task automatic test_default_settings();
      write_reg(CSR_EXACT_BOUND, CSR_DATA_W'(EXACT_BOUND_RESET));
      write_reg(CSR_NULL_MOVE, CSR_DATA_W'(NULL_MOVE_RESET));
      run_random_phase(300);
   endtask

   // Receiver readiness: random stalls, steady stretches and requested long holds
   always @(posedge clock) begin : rsp_ready_gen
      int stall_left;
      int hold_served;
      int g;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         stall_left  = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_steady) begin
         rsp_tready <= 1'b1;
      end else begin
         g = pick_gap();
         if (g == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = g - 1;
            rsp_tready <= 1'b0;
         end
      end
   end

   // Compare each result transfer with the oldest expected answer
   always @(posedge clock) begin : answer_check
      probe_answer_type exp_ans;
      probe_answer_type got;
      if (rsp_tvalid && rsp_tready) begin
         got.hit   = rsp_tuser;
         got.move  = rsp_tdata[15:0];
         got.score = rsp_tdata[31:16];
         got.depth = rsp_tdata[39:32];
         got.bound = rsp_tdata[41:40];
         answers_seen++;
         if (got.hit) hits_seen++;
         if (answers_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result hit=%0b move=%h", $time, got.hit, got.move);
         end else begin
            exp_ans = answers_due.pop_front();
            if (got.hit !== exp_ans.hit) begin
               mismatches++;
               $display("%0t: hit expected %0b actual %0b", $time, exp_ans.hit, got.hit);
            end
            if (got.move !== exp_ans.move) begin
               mismatches++;
               $display("%0t: found_move expected %h actual %h", $time, exp_ans.move,
                        got.move);
            end
            if (got.score !== exp_ans.score) begin
               mismatches++;
               $display("%0t: found_score expected %0d actual %0d", $time, exp_ans.score,
                        got.score);
            end
            if (got.depth !== exp_ans.depth) begin
               mismatches++;
               $display("%0t: found_depth expected %0d actual %0d", $time, exp_ans.depth,
                        got.depth);
            end
            if (got.bound !== exp_ans.bound) begin
               mismatches++;
               $display("%0t: found_bound expected %0d actual %0d", $time, exp_ans.bound,
                        got.bound);
            end
         end
      end
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin : idle_watchdog
      int idle_cycles;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d answers outstanding", $time,
                     idle_cycles, answers_due.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_register_settings();
      test_backpressure();
      test_default_settings();
      wait_answers_drained();
      repeat (10) @(posedge clock);
      if (answers_due.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected answers never arrived", $time, answers_due.size());
      end
      $display("Covered %0d probes (%0d hits), %0d stores (%0d dropped), %0d clears,",
               probes_sent, hits_seen, stores_sent, stores_dropped, clears_sent);
      $display("%0d register writes, %0d results checked, %0d mismatches", reg_writes,
               answers_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
